// ----- rtl/mbgs_pkg.sv -----
// shared constants and transaction types for the masked bit gather/scatter block
package mbgs_pkg;

    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(DATA_W + 1);
    localparam int RANK_W   = $clog2(DATA_W);
    localparam int SW_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = (DATA_W > SW_W) ? DATA_W : SW_W;
    localparam int GRP      = 8;
    localparam int NGRP     = (DATA_W + GRP - 1) / GRP;
    localparam int LOC_W    = $clog2(GRP + 1);
    localparam int STAGES   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_MASK     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = CFG_IDX_W'(1);

    localparam logic MODE_GATHER  = 1'b0;
    localparam logic MODE_SCATTER = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data;
    } t_in_s;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [CNT_W-1:0]  bits_kept;
    } t_out_s;

endpackage

// ----- rtl/mbgs_remap.sv -----
// gather or scatter of data bits from per-bit ranks of the limited mask
module mbgs_remap
    import mbgs_pkg::*;
(
    input  logic              i_mode,
    input  logic [DATA_W-1:0] i_data,
    input  logic [DATA_W-1:0] i_mask,
    input  logic [RANK_W-1:0] i_rank [DATA_W],
    output logic [DATA_W-1:0] o_result
);

    logic [DATA_W-1:0] gather;
    logic [DATA_W-1:0] scatter;

    always_comb begin
        gather = '0;
        for (int k = 0; k < DATA_W; k++) begin
            for (int i = k; i < DATA_W; i++) begin
                if (i_mask[i] && i_data[i] && (i_rank[i] == RANK_W'(k))) begin
                    gather[k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            scatter[i] = i_mask[i] & i_data[i_rank[i]];
        end
    end

    assign o_result = (i_mode == MODE_SCATTER) ? scatter : gather;

endmodule

// ----- rtl/masked_bit_gather_scatter.sv -----
// top level: config registers, rank pipeline and output stage of the bit gather/scatter block
//
//  channel   direction  signals                        payload
//  input     in         i_in_valid, o_in_stall         i_in   (mode, data)
//  output    out        o_out_valid, i_out_stall       o_out  (result, bits_kept)
//  config    in         i_cfg_we, i_cfg_idx            i_cfg_data
//
//  four register stages: mask limit, byte-local ranks, full ranks, remap
//  one transaction per cycle unless stalled; o_out_valid is the stage 4 valid bit
//  reset clears stage valid bits and sets bit_mask to 0, source_width to 32
//  a stall only holds stages that are full; empty stages keep filling
module masked_bit_gather_scatter
    import mbgs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_s                i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_s               o_out
);

    logic [DATA_W-1:0] r_bit_mask;
    logic [SW_W-1:0]   r_source_width;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] adv;

    logic [DATA_W-1:0] mask_lim;
    logic              sw_sat;

    // stage 1
    logic              r_s1_mode;
    logic [DATA_W-1:0] r_s1_data;
    logic [DATA_W-1:0] r_s1_mask;

    // stage 2
    logic              r_s2_mode;
    logic [DATA_W-1:0] r_s2_data;
    logic [DATA_W-1:0] r_s2_mask;
    logic [LOC_W-1:0]  r_s2_loc [DATA_W];
    logic [LOC_W-1:0]  r_s2_gcnt [NGRP];
    logic [LOC_W-1:0]  n_s2_loc [DATA_W];
    logic [LOC_W-1:0]  n_s2_gcnt [NGRP];

    // stage 3
    logic              r_s3_mode;
    logic [DATA_W-1:0] r_s3_data;
    logic [DATA_W-1:0] r_s3_mask;
    logic [RANK_W-1:0] r_s3_rank [DATA_W];
    logic [CNT_W-1:0]  r_s3_cnt;
    logic [RANK_W-1:0] n_s3_rank [DATA_W];
    logic [CNT_W-1:0]  n_s3_cnt;

    // stage 4
    logic [DATA_W-1:0] r_s4_result;
    logic [CNT_W-1:0]  r_s4_cnt;
    logic [DATA_W-1:0] n_s4_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_mask     <= '0;
            r_source_width <= SW_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BIT_MASK:     r_bit_mask     <= i_cfg_data[DATA_W-1:0];
                REG_SOURCE_WIDTH: r_source_width <= i_cfg_data[SW_W-1:0];
                default: ;
            endcase
        end
    end

    // backpressure chain
    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || !i_out_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // mask limited to the working width
    assign sw_sat = ({1'b0, r_source_width} >= (SW_W + 1)'(DATA_W));

    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            mask_lim[i] = r_bit_mask[i] &&
                          (sw_sat || ((SW_W + 1)'(i) < {1'b0, r_source_width}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_in_valid) begin
            r_s1_mode <= i_in.mode;
            r_s1_data <= i_in.data;
            r_s1_mask <= mask_lim;
        end
    end

    // ranks within each byte group
    always_comb begin
        logic [LOC_W-1:0] acc;
        for (int i = 0; i < DATA_W; i++) begin
            n_s2_loc[i] = '0;
        end
        for (int g = 0; g < NGRP; g++) begin
            acc = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DATA_W) begin
                    n_s2_loc[g * GRP + j] = acc;
                    acc = acc + LOC_W'(r_s1_mask[g * GRP + j]);
                end
            end
            n_s2_gcnt[g] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1] && r_vld[0]) begin
            r_s2_mode <= r_s1_mode;
            r_s2_data <= r_s1_data;
            r_s2_mask <= r_s1_mask;
            r_s2_loc  <= n_s2_loc;
            r_s2_gcnt <= n_s2_gcnt;
        end
    end

    // group offsets added to local ranks
    always_comb begin
        logic [CNT_W-1:0] off;
        off = '0;
        for (int g = 0; g < NGRP; g++) begin
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DATA_W) begin
                    n_s3_rank[g * GRP + j] = RANK_W'(off + CNT_W'(r_s2_loc[g * GRP + j]));
                end
            end
            off = off + CNT_W'(r_s2_gcnt[g]);
        end
        n_s3_cnt = off;
    end

    always_ff @(posedge i_clk) begin
        if (adv[2] && r_vld[1]) begin
            r_s3_mode <= r_s2_mode;
            r_s3_data <= r_s2_data;
            r_s3_mask <= r_s2_mask;
            r_s3_rank <= n_s3_rank;
            r_s3_cnt  <= n_s3_cnt;
        end
    end

    mbgs_remap u_remap (
        .i_mode   (r_s3_mode),
        .i_data   (r_s3_data),
        .i_mask   (r_s3_mask),
        .i_rank   (r_s3_rank),
        .o_result (n_s4_result)
    );

    always_ff @(posedge i_clk) begin
        if (adv[3] && r_vld[2]) begin
            r_s4_result <= n_s4_result;
            r_s4_cnt    <= r_s3_cnt;
        end
    end

    assign o_out_valid     = r_vld[STAGES-1];
    assign o_out.result    = r_s4_result;
    assign o_out.bits_kept = r_s4_cnt;

endmodule

// ----- verif/tb.sv -----
// testbench for masked_bit_gather_scatter: directed and random transactions checked against a predictor
`timescale 1ns / 1ps

module tb
    import mbgs_pkg::*;
();

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_style;

    localparam int HOLD_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    t_in_s                in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_s               out_item;

    logic [DATA_W-1:0]    mask_reg;
    logic [SW_W-1:0]      width_reg;
    t_out_s               remap_expected[$];
    t_out_s               want;
    int                   errors = 0;

    t_stall_style         stall_style;
    int                   hold_req;
    int                   hold_done = 0;
    int                   hold_left = 0;
    int                   pat_cnt = 0;
    bit                   gaps_on = 1'b0;
    int                   burst_left = 0;

    masked_bit_gather_scatter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_out_s remap_predict(logic mode, logic [DATA_W-1:0] data);
        int unsigned w;
        int          k;
        t_out_s      r;
        w = width_reg;
        if (w > DATA_W) begin
            w = DATA_W;
        end
        r = '0;
        k = 0;
        for (int i = 0; i < w; i++) begin
            if (mask_reg[i]) begin
                if (mode == MODE_SCATTER) begin
                    r.result[i] = data[k];
                end else begin
                    r.result[k] = data[i];
                end
                k++;
            end
        end
        r.bits_kept = CNT_W'(k);
        return r;
    endfunction

    task automatic send_item(input logic mode, input logic [DATA_W-1:0] data);
        t_in_s item;
        if (gaps_on && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        item.mode = mode;
        item.data = data;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        remap_expected.push_back(remap_predict(mode, data));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (remap_expected.size() != 0) @(posedge clk);
        repeat (STAGES + 4) @(posedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] mask, input logic [CFG_W-1:0] width);
        wait_for_drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_BIT_MASK;
        cfg_data <= mask;
        @(posedge clk);
        mask_reg = mask;
        cfg_idx  <= REG_SOURCE_WIDTH;
        cfg_data <= width;
        @(posedge clk);
        width_reg = width[SW_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: long hold-offs on request, otherwise the current stall style
    always @(posedge clk) begin
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
        end
        pat_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            case (stall_style)
                STALL_RANDOM:  out_stall <= ($urandom_range(99) < 35);
                STALL_PATTERN: out_stall <= ((pat_cnt % 5) >= 3);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (remap_expected.size() == 0) begin
                $display("%0t: unexpected transaction result %h bits_kept %0d",
                         $time, out_item.result, out_item.bits_kept);
                errors++;
            end else begin
                want = remap_expected.pop_front();
                if (out_item.result !== want.result) begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want.result, out_item.result);
                    errors++;
                end
                if (out_item.bits_kept !== want.bits_kept) begin
                    $display("%0t: bits_kept mismatch expected %0d actual %0d",
                             $time, want.bits_kept, out_item.bits_kept);
                    errors++;
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom) & DATA_W'($urandom);
            3:       return DATA_W'($urandom) | DATA_W'($urandom);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(MODE_GATHER, '1);
        send_item(MODE_SCATTER, '1);
    endtask

    task automatic test_directed_edges();
        configure('1, 32);
        send_item(MODE_GATHER, 32'h1234_5678);
        send_item(MODE_SCATTER, 32'h8765_4321);
        send_item(MODE_GATHER, '0);
        send_item(MODE_SCATTER, '1);
        configure(32'hAAAA_AAAA, 32);
        send_item(MODE_GATHER, '1);
        send_item(MODE_SCATTER, 32'h0000_FFFF);
        send_item(MODE_SCATTER, '1);
        configure(32'h8000_0001, 32);
        send_item(MODE_GATHER, 32'h8000_0001);
        send_item(MODE_SCATTER, 32'h0000_0003);
        configure(32'h8000_0001, 31);
        send_item(MODE_GATHER, 32'h8000_0001);
        configure('1, 0);
        send_item(MODE_GATHER, '1);
        send_item(MODE_SCATTER, '1);
        configure('1, 63);
        send_item(MODE_GATHER, 32'hDEAD_BEEF);
        send_item(MODE_SCATTER, 32'hDEAD_BEEF);
        // upper bits of the width write fall outside the register
        configure(32'h00FF_00FF, 32'hFFFF_FFD0);
        send_item(MODE_GATHER, '1);
        send_item(MODE_SCATTER, '1);
        configure(32'h0000_0001, 1);
        send_item(MODE_SCATTER, '1);
    endtask

    task automatic test_random_sweep();
        logic [DATA_W-1:0] mask;
        logic [CFG_W-1:0]  width;
        for (int p = 0; p < 28; p++) begin
            case ($urandom_range(5))
                0:       mask = '1;
                1:       mask = DATA_W'($urandom) & DATA_W'($urandom);
                2:       mask = DATA_W'($urandom) | DATA_W'($urandom);
                default: mask = DATA_W'($urandom);
            endcase
            if (p == 0) begin
                mask = '0;
            end
            case ($urandom_range(7))
                0:       width = 0;
                1:       width = 1;
                2:       width = 31;
                3:       width = 32;
                4:       width = 33;
                5:       width = 63;
                default: width = $urandom_range(63);
            endcase
            configure(mask, width);
            stall_style <= t_stall_style'(p % 3);
            gaps_on = (p % 4) != 0;
            burst_left = 0;
            for (int n = 0; n < 50; n++) begin
                send_item(logic'($urandom_range(1)), random_data());
            end
        end
    endtask

    task automatic test_backpressure();
        configure(DATA_W'($urandom), 32);
        for (int r = 0; r < 2; r++) begin
            stall_style <= (r == 0) ? STALL_NONE : STALL_RANDOM;
            gaps_on = 1'b0;
            hold_req <= hold_req + 1;
            for (int n = 0; n < 30; n++) begin
                send_item(logic'($urandom_range(1)), random_data());
            end
            wait_for_drain();
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_idx     <= REG_BIT_MASK;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        out_stall   <= 1'b0;
        stall_style <= STALL_NONE;
        hold_req    <= 0;
        mask_reg    = '0;
        width_reg   = SW_W'(32);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_edges();
        test_random_sweep();
        test_backpressure();
        wait_for_drain();
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mbgs_pkg.sv
rtl/mbgs_remap.sv
rtl/masked_bit_gather_scatter.sv
verif/tb.sv
